// ===== sv/gdt_pkg.sv =====
// ----------------------------------------------------------------------------
// gdt_pkg
// Shared types and constants of the graph traversal block.
// ----------------------------------------------------------------------------
package gdt_pkg;

  localparam int NODES       = 64;
  localparam int CHILD_SLOTS = 8;
  localparam int NODE_W      = $clog2(NODES);
  localparam int SLOT_W      = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
  localparam int CNT_W       = $clog2(CHILD_SLOTS + 1);
  localparam int TBL_DEPTH   = NODES * CHILD_SLOTS;
  localparam int GRAPH_DEPTH = TBL_DEPTH + NODES;
  localparam int GADDR_W     = $clog2(GRAPH_DEPTH);
  localparam int WADDR_W     = $clog2(TBL_DEPTH);
  localparam int PTR_W       = WADDR_W + 1;
  localparam int MAXC_W      = 4;
  localparam int PADDR_W     = 3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_NOSTART = 2'd2;

  localparam logic [MAXC_W-1:0] MAXC_RESET = MAXC_W'(8);

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DFS  = 2'd1,
    OP_BFS  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_RD,
    ST_E_WR,
    ST_E_CLR,
    ST_E_OUT,
    ST_POP,
    ST_POP_W,
    ST_EMIT,
    ST_CNT_W,
    ST_CH_W,
    ST_DONE
  } state_e;

endpackage

// ===== sv/gdt_ram.sv =====
// ----------------------------------------------------------------------------
// gdt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/graph_dfs_bfs_traversal.sv =====
// Add-edge item: one result, through E_RD, then E_WR when the edge is stored, then E_CLR and E_OUT.
// Walk item: each emitted node passes POP, POP_W, EMIT and CNT_W, a skipped stack entry POP and
// POP_W, and each child edge read takes a CH_W step, as the graph RAM has a single read port.
// One item is in work at a time; the next is accepted when the last result
// is registered. Reset clears node presence, visit marks and max_children (8).
// ----------------------------------------------------------------------------
// graph_dfs_bfs_traversal
// Directed graph store with depth-first and breadth-first walks.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_traversal import gdt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_op_i,
  input  logic [NODE_W-1:0]  in_src_node_i,
  input  logic [NODE_W-1:0]  in_dst_node_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [NODE_W-1:0]  out_node_o,
  output logic               out_last_o,
  output logic [1:0]         out_status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [NODE_W-1:0] src_q, src_d, dst_q, dst_d, cur_q, cur_d, pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  logic              dnew_q, dnew_d;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, i_q, i_d, cnt_rd, lim, i_nx;
  logic [NODES-1:0]  present_q, present_d, visited_q, visited_d;
  logic [1:0]        res_q, res_d;
  logic [MAXC_W-1:0] maxc_q;
  logic              ov_q, ov_d, ol_q, ol_d;
  logic [NODE_W-1:0] on_q, on_d;
  logic [1:0]        os_q, os_d;
  logic              out_free, is_dfs;

  logic               g_we;
  logic [GADDR_W-1:0] g_waddr, g_raddr;
  logic [NODE_W-1:0]  g_wdata, g_rdata;
  logic               w_we;
  logic [WADDR_W-1:0] w_waddr, w_raddr;
  logic [NODE_W-1:0]  w_wdata, w_rdata;

  gdt_ram #(.WIDTH(NODE_W), .DEPTH(GRAPH_DEPTH)) u_graph_ram (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );

  gdt_ram #(.WIDTH(NODE_W), .DEPTH(TBL_DEPTH)) u_work_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  function automatic logic [GADDR_W-1:0] slot_addr(logic [NODE_W-1:0] n,
                                                    logic [CNT_W-1:0] k);
    return GADDR_W'(n) * GADDR_W'(CHILD_SLOTS) + GADDR_W'(k[SLOT_W-1:0]);
  endfunction

  function automatic logic [GADDR_W-1:0] count_addr(logic [NODE_W-1:0] n);
    return GADDR_W'(TBL_DEPTH) + GADDR_W'(n);
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(maxc_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxc_q <= MAXC_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      maxc_q <= pwdata[MAXC_W-1:0];
    end
  end

  assign lim      = (maxc_q > MAXC_W'(CHILD_SLOTS)) ? CNT_W'(CHILD_SLOTS) : CNT_W'(maxc_q);
  assign out_free = !ov_q || out_ready_i;
  assign is_dfs   = (op_q == OP_DFS);
  assign i_nx     = i_q + CNT_W'(1);

  always_comb begin
    state_d = state_q; op_d = op_q; src_d = src_q; dst_d = dst_q;
    cur_d = cur_q; pend_d = pend_q; pend_v_d = pend_v_q; dnew_d = dnew_q;
    head_d = head_q; tail_d = tail_q; cnt_d = cnt_q; i_d = i_q;
    present_d = present_q; visited_d = visited_q; res_d = res_q;
    ov_d = ov_q && !out_ready_i; on_d = on_q; ol_d = ol_q; os_d = os_q;
    in_ready_o = 1'b0;
    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
    w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;
    cnt_rd = present_q[cur_q] ? CNT_W'(g_rdata) : '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        g_raddr = count_addr(in_src_node_i);
        if (in_valid_i) begin
          op_d = op_e'(in_op_i); src_d = in_src_node_i; dst_d = in_dst_node_i;
          unique case (op_e'(in_op_i))
            OP_ADD: state_d = ST_E_RD;
            OP_DFS, OP_BFS: begin
              if (!present_q[in_src_node_i]) begin
                res_d = STAT_NOSTART;
                state_d = ST_E_OUT;
              end else begin
                visited_d = '0;
                if (op_e'(in_op_i) == OP_BFS) visited_d[in_src_node_i] = 1'b1;
                head_d = '0;
                tail_d = PTR_W'(1);
                w_we = 1'b1; w_waddr = '0; w_wdata = in_src_node_i;
                pend_v_d = 1'b0;
                state_d = ST_POP;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_E_RD: begin
        cnt_d = present_q[src_q] ? CNT_W'(g_rdata) : '0;
        present_d[src_q] = 1'b1;
        present_d[dst_q] = 1'b1;
        dnew_d = !present_q[dst_q] && (dst_q != src_q);
        if (cnt_d >= lim) begin
          res_d = STAT_FULL;
          if (!present_q[src_q]) begin
            g_we = 1'b1; g_waddr = count_addr(src_q); g_wdata = '0;
          end
          state_d = ST_E_CLR;
        end else begin
          g_we = 1'b1; g_waddr = slot_addr(src_q, cnt_d); g_wdata = dst_q;
          state_d = ST_E_WR;
        end
      end
      ST_E_WR: begin
        g_we = 1'b1; g_waddr = count_addr(src_q); g_wdata = NODE_W'(cnt_q + CNT_W'(1));
        res_d = STAT_OK;
        state_d = ST_E_CLR;
      end
      ST_E_CLR: begin
        if (dnew_q) begin
          g_we = 1'b1; g_waddr = count_addr(dst_q); g_wdata = '0;
        end
        state_d = ST_E_OUT;
      end
      ST_E_OUT: begin
        if (out_free) begin
          ov_d = 1'b1; on_d = '0; ol_d = 1'b1; os_d = res_q;
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          state_d = ST_DONE;
        end else if (is_dfs) begin
          tail_d = tail_q - PTR_W'(1);
          w_raddr = tail_d[WADDR_W-1:0];
          state_d = ST_POP_W;
        end else begin
          w_raddr = head_q[WADDR_W-1:0];
          head_d = head_q + PTR_W'(1);
          state_d = ST_POP_W;
        end
      end
      ST_POP_W: begin
        cur_d = w_rdata;
        if (is_dfs && visited_q[w_rdata]) begin
          state_d = ST_POP;
        end else begin
          if (is_dfs) visited_d[w_rdata] = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        g_raddr = count_addr(cur_q);
        if (!pend_v_q) begin
          pend_d = cur_q; pend_v_d = 1'b1;
          state_d = ST_CNT_W;
        end else if (out_free) begin
          ov_d = 1'b1; on_d = pend_q; ol_d = 1'b0; os_d = STAT_OK;
          pend_d = cur_q;
          state_d = ST_CNT_W;
        end
      end
      ST_CNT_W: begin
        cnt_d = cnt_rd;
        i_d = '0;
        if (cnt_rd == '0) begin
          state_d = ST_POP;
        end else begin
          g_raddr = slot_addr(cur_q, is_dfs ? cnt_rd - CNT_W'(1) : '0);
          state_d = ST_CH_W;
        end
      end
      ST_CH_W: begin
        if (!visited_q[g_rdata] && tail_q < PTR_W'(TBL_DEPTH)) begin
          w_we = 1'b1; w_waddr = tail_q[WADDR_W-1:0]; w_wdata = g_rdata;
          tail_d = tail_q + PTR_W'(1);
          if (!is_dfs) visited_d[g_rdata] = 1'b1;
        end
        i_d = i_nx;
        if (i_nx == cnt_q) begin
          state_d = ST_POP;
        end else begin
          g_raddr = slot_addr(cur_q, is_dfs ? cnt_q - CNT_W'(1) - i_nx : i_nx);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d = 1'b1; on_d = pend_q; ol_d = 1'b1; os_d = STAT_OK;
          pend_v_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_NONE;
      pend_v_q  <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      present_q <= '0;
      visited_q <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      pend_v_q  <= pend_v_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      present_q <= present_d;
      visited_q <= visited_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    dst_q  <= dst_d;
    cur_q  <= cur_d;
    pend_q <= pend_d;
    dnew_q <= dnew_d;
    cnt_q  <= cnt_d;
    i_q    <= i_d;
    res_q  <= res_d;
    on_q   <= on_d;
    ol_q   <= ol_d;
    os_q   <= os_d;
  end

  assign out_valid_o  = ov_q;
  assign out_node_o   = on_q;
  assign out_last_o   = ol_q;
  assign out_status_o = os_q;

endmodule

// ===== sv/gdt_checker.sv =====
// ----------------------------------------------------------------------------
// gdt_checker
// Port-level checks of the graph traversal block.
// ----------------------------------------------------------------------------
module gdt_checker import gdt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [NODE_W-1:0] out_node_o,
  input logic              out_last_o,
  input logic [1:0]        out_status_o,
  input logic              pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_node_o))
    else $error("Result item changed while stalled.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_status_o != 2'd3)
    else $error("Result item carries an unused status code.");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o != STAT_OK |-> out_last_o && out_node_o == '0)
    else $error("Error result item is not a single final item.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("Configuration port inserted a wait state.");

endmodule

bind graph_dfs_bfs_traversal gdt_checker u_gdt_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Graph traversal block testbench
// Builds small random graphs through add-edge items, walks them depth first
// and breadth first, and checks every result against an in-bench graph model
// under several child limits and several idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import gdt_pkg::*;

  typedef struct packed {
    op_e              op;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } walk_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic [1:0]        status;
  } visit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] in_op_i = '0;
  logic [NODE_W-1:0] in_src_node_i = '0;
  logic [NODE_W-1:0] in_dst_node_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [NODE_W-1:0] out_node_o;
  logic out_last_o;
  logic [1:0] out_status_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  graph_dfs_bfs_traversal u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  walk_cmd_t cmd_q[$];
  visit_t    visit_q[$];
  int        errors = 0;
  int        n_items = 0;
  int        n_visits = 0;
  int        send_idle = 0;
  int        recv_stall = 0;

  // Graph model.
  logic       g_present[NODES];
  int         g_count[NODES];
  logic [NODE_W-1:0] g_child[NODES][CHILD_SLOTS];
  int         g_limit;

  function automatic void graph_clear();
    for (int i = 0; i < NODES; i++) begin
      g_present[i] = 1'b0;
      g_count[i] = 0;
    end
    g_limit = 8;
  endfunction

  function automatic void push_visit(int node, bit last, logic [1:0] st);
    visit_t v;
    v.node = node[NODE_W-1:0];
    v.last = last;
    v.status = st;
    visit_q.push_back(v);
  endfunction

  function automatic void predict_visits(walk_cmd_t c);
    int lim;
    int s;
    int d;
    int cur;
    int cnt;
    int ch;
    int emitted;
    bit seen[NODES];
    int work[$];
    s = c.src;
    d = c.dst;
    if (c.op == OP_ADD) begin
      g_present[s] = 1'b1;
      g_present[d] = 1'b1;
      lim = (g_limit > CHILD_SLOTS) ? CHILD_SLOTS : g_limit;
      if (g_count[s] >= lim) begin
        push_visit(0, 1'b1, STAT_FULL);
      end else begin
        g_child[s][g_count[s]] = c.dst;
        g_count[s]++;
        push_visit(0, 1'b1, STAT_OK);
      end
    end else if (c.op == OP_DFS || c.op == OP_BFS) begin
      if (!g_present[s]) begin
        push_visit(0, 1'b1, STAT_NOSTART);
      end else begin
        emitted = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        work.push_back(s);
        if (c.op == OP_BFS) seen[s] = 1'b1;
        while (work.size() > 0) begin
          if (c.op == OP_DFS) begin
            cur = work.pop_back();
            if (seen[cur]) continue;
            seen[cur] = 1'b1;
          end else begin
            cur = work.pop_front();
          end
          push_visit(cur, 1'b0, STAT_OK);
          emitted++;
          cnt = g_count[cur];
          for (int i = 0; i < cnt; i++) begin
            ch = g_child[cur][(c.op == OP_DFS) ? cnt - 1 - i : i];
            if (!seen[ch]) begin
              work.push_back(ch);
              if (c.op == OP_BFS) seen[ch] = 1'b1;
            end
          end
        end
        visit_q[visit_q.size() - 1].last = 1'b1;
      end
    end
  endfunction

  // Driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) predict_visits(walk_cmd_t'({in_op_i, in_src_node_i, in_dst_node_i}));
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          walk_cmd_t c;
          c = cmd_q.pop_front();
          in_valid_i <= 1'b1;
          in_op_i <= c.op;
          in_src_node_i <= c.src;
          in_dst_node_i <= c.dst;
          n_items++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      visit_t got;
      visit_t exp_v;
      got.node = out_node_o;
      got.last = out_last_o;
      got.status = out_status_o;
      n_visits++;
      if (visit_q.size() == 0) begin
        $display("%0t: unexpected result node=%0d last=%0d status=%0d",
                 $time, got.node, got.last, got.status);
        errors++;
      end else begin
        exp_v = visit_q.pop_front();
        if (got !== exp_v) begin
          $display("%0t: expected node=%0d last=%0d status=%0d, got node=%0d last=%0d status=%0d",
                   $time, exp_v.node, exp_v.last, exp_v.status,
                   got.node, got.last, got.status);
          errors++;
        end
      end
    end
  end

  task automatic write_limit(int value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    g_limit = value & 15;
  endtask

  task automatic add_cmd(op_e op, int s, int d);
    walk_cmd_t c;
    c.op = op;
    c.src = s[NODE_W-1:0];
    c.dst = d[NODE_W-1:0];
    cmd_q.push_back(c);
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid_i || visit_q.size() > 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  // Random mix of edge inserts and walks on a node window.
  task automatic random_phase(int count, int base, int span);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 55) add_cmd(OP_ADD, base + $urandom_range(span), base + $urandom_range(span));
      else if (r < 75) add_cmd(OP_DFS, base + $urandom_range(span), $urandom_range(63));
      else if (r < 95) add_cmd(OP_BFS, base + $urandom_range(span), $urandom_range(63));
      else if (r < 98) add_cmd(op_e'($urandom_range(2)), $urandom_range(63), $urandom_range(63));
      else add_cmd(OP_NONE, $urandom_range(63), $urandom_range(63));
    end
  endtask

  initial begin
    graph_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_cmd(OP_DFS, 5, 0);
    add_cmd(OP_ADD, 0, 63);
    add_cmd(OP_ADD, 0, 1);
    add_cmd(OP_ADD, 1, 2);
    add_cmd(OP_ADD, 2, 0);
    add_cmd(OP_ADD, 1, 1);
    add_cmd(OP_ADD, 1, 2);
    add_cmd(OP_ADD, 63, 42);
    add_cmd(OP_ADD, 42, 21);
    add_cmd(OP_NONE, 0, 1);
    add_cmd(OP_DFS, 0, 63);
    add_cmd(OP_BFS, 0, 0);
    add_cmd(OP_BFS, 63, 0);
    add_cmd(OP_BFS, 33, 0);
    for (int i = 0; i < 9; i++) add_cmd(OP_ADD, 21, 10 + i);
    add_cmd(OP_DFS, 42, 0);
    add_cmd(OP_BFS, 21, 0);
    drain();

    write_limit(0);
    add_cmd(OP_ADD, 50, 51);
    add_cmd(OP_DFS, 50, 0);
    add_cmd(OP_BFS, 51, 0);
    drain();
    write_limit(15);
    send_idle = 75;
    random_phase(20, 0, 15);
    drain();
    write_limit(1);
    send_idle = 0;
    recv_stall = 75;
    random_phase(20, 16, 15);
    drain();
    write_limit(3);
    send_idle = 32;
    recv_stall = 32;
    random_phase(20, 32, 31);
    drain();
    write_limit(8);
    send_idle = 0;
    recv_stall = 0;
    random_phase(20, 0, 63);
    drain();

    $display("Sent %0d items over five child limits and four idling patterns.", n_items);
    $display("Checked %0d results of edge inserts and graph walks.", n_visits);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
